// ===== sv/lrupr_pkg.sv =====
`default_nettype none

package lrupr_pkg;

   localparam int MAX_FRAMES = 8;
   localparam int PAGE_BITS  = 16;
   localparam int MIN_FRAMES = 3;

   localparam int FRAME_W     = $clog2(MAX_FRAMES);
   localparam int RANK_W      = FRAME_W;
   localparam int LIMIT_W     = RANK_W + 1;
   localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
   localparam int CFG_W       = 4;
   localparam int FAULT_W     = 16;
   localparam int FRAME_IDX_W = 3;
   localparam int RES_W       = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(MIN_FRAMES);
   localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

   // register word indexes
   localparam logic [CSR_ADDR_W-3:0] REG_FRAMES_IN_USE = '0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frames_last;   // highest active frame index
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/lru_page_replacement.sv =====
// Flow: accept, scan pass, rank update pass, then the output register.
// One item is taken at a time, in the idle state; a finished item may wait in the
// output register while the next one is taken.
// The set is walked one frame a cycle through a single compare/increment unit: a scan pass
// over the active frames, then a rank update pass over all frames.
// Reset: synchronous, active high; frames empty, ranks and fault count zero, frames_in_use 3.
`default_nettype none

module lru_page_replacement (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [lrupr_pkg::PAGE_BITS-1:0]    req_page_number,
   input  wire logic                               req_start_new_run,
   // response channel
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic                               rsp_hit,
   output      logic [lrupr_pkg::FRAME_IDX_W-1:0]  rsp_frame_index,
   output      logic                               rsp_evicted_valid,
   output      logic [lrupr_pkg::PAGE_BITS-1:0]    rsp_evicted_page,
   output      logic [lrupr_pkg::FAULT_W-1:0]      rsp_fault_count,
   output      logic [lrupr_pkg::RES_W-1:0]        rsp_resident_count,
   // configuration
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lrupr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [lrupr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [lrupr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                               csr_pready
);
   import lrupr_pkg::*;

   cfg_type cfg;

   lrupr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------
   // Frame store. Pages carry no reset; valid bits and ranks do.
   // ------------------------------------------------------------------
   logic [PAGE_BITS-1:0]  page_mem [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;
   logic [RANK_W-1:0]     rank_ff  [MAX_FRAMES];
   logic [FAULT_W-1:0]    faults_ff;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [FRAME_W-1:0]    idx_ff;          // shared walk index for both passes
   logic                  accept;
   logic                  scan_last;
   logic                  upd_last;
   logic                  out_free;
   logic                  load_out;

   assign accept    = req_valid && !req_stall;
   assign scan_last = (idx_ff == cfg.frames_last);
   assign upd_last  = (idx_ff == FRAME_W'(MAX_FRAMES - 1));
   assign out_free  = !rsp_valid || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid)  state_in = ST_SCAN;
         ST_SCAN:   if (scan_last)  state_in = ST_UPDATE;
         ST_UPDATE: if (upd_last)   state_in = ST_DONE;
         ST_DONE:   if (out_free)   state_in = ST_IDLE;
         default:                   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SCAN:   req_stall = 1'b1;
         ST_UPDATE: req_stall = 1'b1;
         ST_DONE:   load_out  = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // Scan pass: one active frame a cycle. Records first hit, first empty
   // frame, first frame of highest rank, and the resident count.
   // ------------------------------------------------------------------
   logic [PAGE_BITS-1:0]  req_page_ff;
   logic                  found_ff;
   logic [FRAME_W-1:0]    hit_slot_ff;
   logic [RANK_W-1:0]     hit_rank_ff;
   logic                  empty_ff;
   logic [FRAME_W-1:0]    empty_slot_ff;
   logic [RANK_W-1:0]     worst_ff;
   logic [FRAME_W-1:0]    victim_ff;
   logic [CNT_W-1:0]      resident_ff;
   logic [PAGE_BITS-1:0]  ev_page_ff;

   logic                  cur_valid;
   logic [PAGE_BITS-1:0]  cur_page;
   logic [RANK_W-1:0]     cur_rank;
   logic                  cur_match;

   assign cur_valid = valid_ff[idx_ff];
   assign cur_page  = page_mem[idx_ff];
   assign cur_rank  = rank_ff[idx_ff];
   assign cur_match = cur_valid && (cur_page == req_page_ff);

   // decision taken from the scan results
   logic [FRAME_W-1:0]    slot;
   logic [LIMIT_W-1:0]    limit;
   logic                  evict;
   logic                  fill;

   always_comb begin
      evict = !found_ff && !empty_ff;
      fill  = !found_ff && empty_ff;
      if (found_ff) begin
         slot  = hit_slot_ff;
         limit = LIMIT_W'(hit_rank_ff);
      end else if (empty_ff) begin
         slot  = empty_slot_ff;
         limit = LIMIT_W'(MAX_FRAMES);
      end else begin
         slot  = victim_ff;
         limit = LIMIT_W'(worst_ff);
      end
   end

   logic                  ages;
   assign ages = cur_valid && ({1'b0, cur_rank} < limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         valid_ff  <= '0;
         faults_ff <= '0;
         for (int f = 0; f < MAX_FRAMES; f++) begin
            rank_ff[f] <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (accept && req_start_new_run) begin
                  valid_ff  <= '0;
                  faults_ff <= '0;
                  for (int f = 0; f < MAX_FRAMES; f++) begin
                     rank_ff[f] <= '0;
                  end
               end
            end
            ST_SCAN: begin
               idx_ff <= scan_last ? '0 : idx_ff + FRAME_W'(1);
            end
            ST_UPDATE: begin
               idx_ff <= idx_ff + FRAME_W'(1);
               if (idx_ff == slot) begin
                  rank_ff[idx_ff] <= '0;
                  if (!found_ff) begin
                     valid_ff[idx_ff] <= 1'b1;
                  end
               end else if (ages) begin
                  rank_ff[idx_ff] <= cur_rank + RANK_W'(1);
               end
               if (upd_last && !found_ff && (faults_ff != FAULT_MAX)) begin
                  faults_ff <= faults_ff + FAULT_W'(1);
               end
            end
            ST_DONE: idx_ff <= '0;
            default: idx_ff <= '0;
         endcase
      end
   end

   // payload side of the walk
   always_ff @(posedge clock) begin
      if (accept) begin
         req_page_ff <= req_page_number;
         found_ff    <= 1'b0;
         empty_ff    <= 1'b0;
         resident_ff <= '0;
         ev_page_ff  <= '0;
         worst_ff    <= '0;
         victim_ff   <= '0;
      end
      if (state_ff == ST_SCAN) begin
         if (cur_match && !found_ff) begin
            found_ff    <= 1'b1;
            hit_slot_ff <= idx_ff;
            hit_rank_ff <= cur_rank;
         end
         if (!cur_valid && !empty_ff) begin
            empty_ff      <= 1'b1;
            empty_slot_ff <= idx_ff;
         end
         if ((idx_ff == '0) || (cur_rank > worst_ff)) begin
            worst_ff  <= cur_rank;
            victim_ff <= idx_ff;
         end
         resident_ff <= resident_ff + CNT_W'(cur_valid);
      end
      if ((state_ff == ST_UPDATE) && (idx_ff == slot) && !found_ff) begin
         page_mem[idx_ff] <= req_page_ff;
         if (evict) begin
            ev_page_ff <= cur_page;
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register: holds a finished item while the next one runs
   // ------------------------------------------------------------------
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_hit            <= found_ff;
         rsp_frame_index    <= FRAME_IDX_W'(slot);
         rsp_evicted_valid  <= evict;
         rsp_evicted_page   <= ev_page_ff;
         rsp_fault_count    <= faults_ff;
         rsp_resident_count <= RES_W'(resident_ff + CNT_W'(fill));
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/lrupr_csr.sv =====
`default_nettype none

module lrupr_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lrupr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [lrupr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [lrupr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                               csr_pready,
   output      lrupr_pkg::cfg_type                 cfg
);
   import lrupr_pkg::*;

   logic [CFG_W-1:0]        frames_in_use_ff;
   logic [CFG_W-1:0]        frames_in_use_in;
   logic                    wr_hit;
   logic [CFG_W:0]          frames_eff;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[CSR_ADDR_W-1:2] == REG_FRAMES_IN_USE);

   always_comb begin
      frames_in_use_in = frames_in_use_ff;
      if (wr_hit) begin
         frames_in_use_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= CFG_RESET;
      end else begin
         frames_in_use_ff <= frames_in_use_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1:2])
         REG_FRAMES_IN_USE: csr_prdata = CSR_DATA_W'(frames_in_use_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // clamp to the managed range
   always_comb begin
      if ({1'b0, frames_in_use_ff} < (CFG_W+1)'(MIN_FRAMES)) begin
         frames_eff = (CFG_W+1)'(MIN_FRAMES);
      end else if ({1'b0, frames_in_use_ff} > (CFG_W+1)'(MAX_FRAMES)) begin
         frames_eff = (CFG_W+1)'(MAX_FRAMES);
      end else begin
         frames_eff = {1'b0, frames_in_use_ff};
      end
      cfg.frames_last = FRAME_W'(frames_eff - (CFG_W+1)'(1));
   end

endmodule

`default_nettype wire

// ===== tb/lru_page_replacement_test.sv =====
module lru_page_replacement_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lrupr_pkg::*;

   // ------------------------------------------------------------------
   // Run shaping
   // ------------------------------------------------------------------
   localparam int RANDOM_ITEMS   = 1000;   // random references, all phases together
   localparam int SETTLE_CYCLES  = 40;     // longer than the full walk of one item
   localparam int HOLDOFF_CYCLES = 300;    // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no item moving on either side

   // frames_in_use sits at word 0
   localparam logic [CSR_ADDR_W-1:0] FRAMES_ADDR = {REG_FRAMES_IN_USE, 2'b00};

   // one result item as the block reports it
   typedef struct packed {
      logic                   hit;
      logic [FRAME_IDX_W-1:0] frame;
      logic                   evicted;
      logic [PAGE_BITS-1:0]   evicted_page;
      logic [FAULT_W-1:0]     faults;
      logic [RES_W-1:0]       resident;
   } page_outcome_type;

   // ------------------------------------------------------------------
   // Block ports; every driven input known from time zero
   // ------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PAGE_BITS-1:0]   req_page_number = '0;
   logic                   req_start_new_run = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_hit;
   logic [FRAME_IDX_W-1:0] rsp_frame_index;
   logic                   rsp_evicted_valid;
   logic [PAGE_BITS-1:0]   rsp_evicted_page;
   logic [FAULT_W-1:0]     rsp_fault_count;
   logic [RES_W-1:0]       rsp_resident_count;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   lru_page_replacement dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_page_number    (req_page_number),
      .req_start_new_run  (req_start_new_run),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_fault_count    (rsp_fault_count),
      .rsp_resident_count (rsp_resident_count),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Frame set mirror: page per frame, occupancy, recency (0 = newest),
   // fault tally and the programmed frame count.
   // ------------------------------------------------------------------
   logic [PAGE_BITS-1:0] frame_holds [MAX_FRAMES];
   bit                   frame_live  [MAX_FRAMES] = '{default: 1'b0};
   logic [RANK_W-1:0]    frame_age   [MAX_FRAMES] = '{default: '0};
   logic [FAULT_W-1:0]   fault_tally = '0;
   logic [CFG_W-1:0]     frames_cfg  = CFG_RESET;

   page_outcome_type outcomes_due [$];   // results owed by the block, oldest first
   int               failures = 0;

   // sender / receiver behavior knobs
   bit sender_bursty   = 1'b0;
   bit receiver_stalls = 1'b0;
   int burst_left      = 0;
   int holdoff_asked   = 0;

   // out-of-range settings clamp to 3..MAX_FRAMES
   function automatic int active_count(logic [CFG_W-1:0] cfg);
      if (cfg < MIN_FRAMES) return MIN_FRAMES;
      if (cfg > MAX_FRAMES) return MAX_FRAMES;
      return int'(cfg);
   endfunction

   // keep becomes newest; live frames newer than limit age by one.
   // Inactive frames still age, the block keeps their ranks.
   function automatic void age_others(int keep, int limit);
      for (int i = 0; i < MAX_FRAMES; i++)
         if (i != keep && frame_live[i] && int'(frame_age[i]) < limit)
            frame_age[i] = frame_age[i] + 1'b1;
      frame_age[keep] = '0;
   endfunction

   // One page reference against the mirror; returns what the block must report.
   function automatic page_outcome_type apply_reference(logic [PAGE_BITS-1:0] page,
                                                        logic start);
      page_outcome_type o;
      int               n;
      int               slot;
      int               worst;
      bit               found;
      bit               empty;
      o     = '0;
      slot  = 0;
      found = 1'b0;
      empty = 1'b0;
      if (start) begin
         frame_live  = '{default: 1'b0};
         frame_age   = '{default: '0};
         fault_tally = '0;
      end
      n = active_count(frames_cfg);
      for (int i = 0; i < n; i++)
         if (!found && frame_live[i] && frame_holds[i] == page) begin
            found = 1'b1;
            slot  = i;
         end
      if (found) begin
         age_others(slot, int'(frame_age[slot]));
      end else begin
         // lowest empty active frame first
         for (int i = 0; i < n; i++)
            if (!empty && !frame_live[i]) begin
               empty = 1'b1;
               slot  = i;
            end
         if (empty) begin
            frame_live[slot]  = 1'b1;
            frame_holds[slot] = page;
            age_others(slot, MAX_FRAMES);
         end else begin
            // oldest active frame; ties go to the lower index
            worst = int'(frame_age[0]);
            for (int i = 1; i < n; i++)
               if (int'(frame_age[i]) > worst) begin
                  worst = int'(frame_age[i]);
                  slot  = i;
               end
            o.evicted         = 1'b1;
            o.evicted_page    = frame_holds[slot];
            frame_holds[slot] = page;
            age_others(slot, worst);
         end
         if (fault_tally != FAULT_MAX) fault_tally = fault_tally + 1'b1;
      end
      o.hit    = found;
      o.frame  = FRAME_IDX_W'(slot);
      o.faults = fault_tally;
      for (int i = 0; i < n; i++)
         if (frame_live[i]) o.resident = o.resident + 1'b1;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Sender: one item per call. In bursty mode valid drops for a random
   // gap between bursts of random length; otherwise valid stays up.
   // ------------------------------------------------------------------
   task automatic send_reference(input logic [PAGE_BITS-1:0] page, input logic start);
      if (sender_bursty && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_valid         <= 1'b1;
      req_page_number   <= page;
      req_start_new_run <= start;
      do @(posedge clock); while (req_stall !== 1'b0);
      outcomes_due.push_back(apply_reference(page, start));
   endtask

   // drop valid, wait for every owed result, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write frames_in_use while idle, then read it back
   task automatic program_frames(input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      settle();
      for (int xfer = 0; xfer < 2; xfer++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= (xfer == 0);
         csr_paddr   <= FRAMES_ADDR;
         csr_pwdata  <= CSR_DATA_W'(value);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (csr_pready !== 1'b1);
         readback = csr_prdata;
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         @(posedge clock);
      end
      frames_cfg = value;
      if (readback !== CSR_DATA_W'(value)) begin
         $error("frames_in_use readback: expected %0h, got %0h", value, readback);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: own stall/pass pattern; a requested hold-off is counted
   // here and overrides the pattern.
   // ------------------------------------------------------------------
   int holdoff_seen = 0;
   int holdoff_left = 0;
   int stall_left   = 0;
   int pass_left    = 0;

   always @(posedge clock) begin
      if (holdoff_asked != holdoff_seen) begin
         holdoff_seen = holdoff_asked;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!receiver_stalls) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (pass_left > 0) begin
         pass_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = $urandom_range(1, 5);
         pass_left  = $urandom_range(1, 9);
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Result check: every accepted item against the oldest owed outcome
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      page_outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (outcomes_due.size() == 0) begin
            $error("result item with nothing owed");
            failures++;
         end else begin
            want = outcomes_due.pop_front();
            check_field("hit", want.hit, rsp_hit);
            check_field("frame_index", want.frame, rsp_frame_index);
            check_field("evicted_valid", want.evicted, rsp_evicted_valid);
            check_field("evicted_page", want.evicted_page, rsp_evicted_page);
            check_field("fault_count", want.faults, rsp_fault_count);
            check_field("resident_count", want.resident, rsp_resident_count);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long with no item moving on either channel
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("lru_page_replacement test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset setting of three frames: fill, hits, LRU eviction, page extremes,
   // start flag dropping resident pages.
   task automatic test_basic_references();
      send_reference(16'h0000, 1'b1);   // fills frame 0
      send_reference(16'hFFFF, 1'b0);
      send_reference(16'h0001, 1'b0);   // set now full
      send_reference(16'h0000, 1'b0);   // hit, 0 newest
      send_reference(16'h8000, 1'b0);   // evicts 0xFFFF
      send_reference(16'h0001, 1'b0);   // hit
      send_reference(16'h0000, 1'b1);   // start: resident 0 misses again
      send_reference(16'h0000, 1'b0);   // hit
      send_reference(16'h5555, 1'b0);
      send_reference(16'hAAAA, 1'b0);
      send_reference(16'h1234, 1'b0);   // evicts 0
      send_reference(16'hAAAA, 1'b0);
      send_reference(16'h5555, 1'b0);
      send_reference(16'h0000, 1'b0);   // evicts 0x1234
   endtask

   // All eight frames, then shrink mid-run (upper frames hidden but kept)
   // and grow again so a hidden page hits.
   task automatic test_frame_count_changes();
      program_frames(CFG_W'(MAX_FRAMES));
      for (int i = 0; i < MAX_FRAMES + 1; i++)
         send_reference(PAGE_BITS'(16'h0100 + i), i == 0);
      program_frames(CFG_W'(MIN_FRAMES));
      send_reference(16'h0105, 1'b0);   // lives in frame 5, now hidden: miss
      program_frames(CFG_W'(MAX_FRAMES));
      send_reference(16'h0106, 1'b0);   // frame 6 visible again: hit
   endtask

   // Random phases: each one a frame setting (extremes and out-of-range
   // first), idling modes and a page pool sized around the frame count.
   task automatic test_random_references();
      logic [CFG_W-1:0]     forced_cfg [6] = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd2, 4'd9};
      logic [CFG_W-1:0]     cfg;
      logic [PAGE_BITS-1:0] base;
      logic [PAGE_BITS-1:0] page;
      int                   sent;
      int                   phase;
      int                   span;
      int                   count;
      bit                   sweep;
      bit                   fresh;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < 6) cfg = forced_cfg[phase];
         else if ($urandom_range(0, 4) == 0) cfg = CFG_W'($urandom_range(0, 15));
         else cfg = CFG_W'($urandom_range(MIN_FRAMES, MAX_FRAMES));
         program_frames(cfg);
         sender_bursty   = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         base  = (phase % 5 == 4) ? 16'hFFFC : PAGE_BITS'($urandom);
         span  = $urandom_range(2, 2 * active_count(cfg) + 2);
         sweep = ($urandom_range(0, 3) == 0);   // cyclic sweep thrashes LRU
         fresh = ($urandom_range(0, 1) == 1);   // else carry frames across the change
         count = $urandom_range(40, 120);
         for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 11))
               0:       page = PAGE_BITS'($urandom);
               1:       page = $urandom_range(0, 1) ? '1 : '0;
               default: page = sweep ? base + PAGE_BITS'(k % span)
                                     : base + PAGE_BITS'($urandom_range(0, span - 1));
            endcase
            send_reference(page, (k == 0 && fresh) || $urandom_range(0, 39) == 0);
         end
         sent += count;
         phase++;
      end
   endtask

   // Receiver holds off while the sender keeps offering back to back.
   task automatic test_output_backpressure();
      settle();
      sender_bursty   = 1'b0;
      receiver_stalls = 1'b1;
      holdoff_asked++;
      for (int k = 0; k < 40; k++)
         send_reference(PAGE_BITS'(16'h0700 + $urandom_range(0, 5)), 1'b0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_references();
      test_frame_count_changes();
      test_random_references();
      test_output_backpressure();

      settle();
      if (failures == 0 && outcomes_due.size() == 0) begin
         $display("lru_page_replacement test passed");
      end else begin
         $display("lru_page_replacement test failed");
      end
      $finish;
   end

endmodule
